// ===== design/bus_action_record_interpreter_unit_macros.svh =====
// assertion helpers for the record interpreter
`ifndef BUS_ACTION_RECORD_INTERPRETER_UNIT_MACROS_SVH
`define BUS_ACTION_RECORD_INTERPRETER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BARI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("record interpreter check failed");

// next-cycle implication, checked outside reset
`define BARI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("record interpreter check failed");

`endif

// ===== design/bari_pkg.sv =====
`default_nettype none
package bari_pkg;

    // action kinds on the result channel
    typedef logic [3:0] t_kind;
    localparam t_kind KIND_RD32    = 4'd0;
    localparam t_kind KIND_RD64    = 4'd1;
    localparam t_kind KIND_WR32    = 4'd2;
    localparam t_kind KIND_WR64    = 4'd3;
    localparam t_kind KIND_RDIGN32 = 4'd4;
    localparam t_kind KIND_RDIGN64 = 4'd5;
    localparam t_kind KIND_POLL32  = 4'd6;
    localparam t_kind KIND_POLL64  = 4'd7;
    localparam t_kind KIND_END     = 4'd8;
    localparam t_kind KIND_ERROR   = 4'd9;

    // record opcodes
    typedef logic [7:0] t_opcode;
    localparam t_opcode OP_END         = 8'h01;
    localparam t_opcode OP_SET_ID      = 8'h09;
    localparam t_opcode OP_SET_ADDR    = 8'h12;
    localparam t_opcode OP_RD32        = 8'h19;
    localparam t_opcode OP_RD64        = 8'h22;
    localparam t_opcode OP_WR32        = 8'h29;
    localparam t_opcode OP_WR64        = 8'h32;
    localparam t_opcode OP_INC_RD32    = 8'h39;
    localparam t_opcode OP_INC_RD64    = 8'h42;
    localparam t_opcode OP_INC_WR32    = 8'h49;
    localparam t_opcode OP_INC_WR64    = 8'h52;
    localparam t_opcode OP_ZERO32      = 8'h58;
    localparam t_opcode OP_ZERO64      = 8'h60;
    localparam t_opcode OP_INC_ZERO32  = 8'h68;
    localparam t_opcode OP_INC_ZERO64  = 8'h70;
    localparam t_opcode OP_RDIGN32     = 8'h79;
    localparam t_opcode OP_RDIGN64     = 8'h82;
    localparam t_opcode OP_INC_RDIGN32 = 8'h89;
    localparam t_opcode OP_INC_RDIGN64 = 8'h92;
    localparam t_opcode OP_POLL32      = 8'h99;
    localparam t_opcode OP_POLL64      = 8'hA2;
    localparam t_opcode OP_SET_NMASK   = 8'hA9;
    localparam t_opcode OP_SET_WMASK   = 8'hB2;

    // address step sizes
    localparam logic [63:0] ADDR_STEP_NARROW = 64'd4;
    localparam logic [63:0] ADDR_STEP_WIDE   = 64'd8;

    // decoded control for one record
    typedef struct packed {
        logic  emit;
        t_kind kind;
        logic  is_wide;
        logic  has_mask;
        logic  zero_val;
        logic  addr_inc;
        logic  set_target;
        logic  set_addr;
        logic  set_nmask;
        logic  set_wmask;
        logic  stop;
    } t_dec;

    // one result beat
    typedef struct packed {
        t_kind       kind;
        logic [31:0] target_id;
        logic [63:0] bus_address;
        logic [63:0] data_value;
        logic [63:0] compare_mask;
    } t_result;

endpackage
`default_nettype wire

// ===== design/bari_decode.sv =====
`default_nettype none
module bari_decode
    import bari_pkg::*;
(
    input  wire logic [7:0] i_opcode,
    output t_dec            o_dec
);

    // opcode to control fields
    always_comb begin
        o_dec          = '0;
        o_dec.emit     = 1'b1;
        o_dec.has_mask = 1'b1;
        o_dec.kind     = KIND_ERROR;
        case (i_opcode)
            OP_END: begin
                o_dec.kind     = KIND_END;
                o_dec.is_wide  = 1'b1;
                o_dec.has_mask = 1'b0;
                o_dec.zero_val = 1'b1;
                o_dec.stop     = 1'b1;
            end
            OP_SET_ID: begin
                o_dec.emit       = 1'b0;
                o_dec.set_target = 1'b1;
            end
            OP_SET_ADDR: begin
                o_dec.emit     = 1'b0;
                o_dec.set_addr = 1'b1;
            end
            OP_SET_NMASK: begin
                o_dec.emit      = 1'b0;
                o_dec.set_nmask = 1'b1;
            end
            OP_SET_WMASK: begin
                o_dec.emit      = 1'b0;
                o_dec.set_wmask = 1'b1;
            end
            OP_RD32: begin
                o_dec.kind = KIND_RD32;
            end
            OP_INC_RD32: begin
                o_dec.kind     = KIND_RD32;
                o_dec.addr_inc = 1'b1;
            end
            OP_RD64: begin
                o_dec.kind    = KIND_RD64;
                o_dec.is_wide = 1'b1;
            end
            OP_INC_RD64: begin
                o_dec.kind     = KIND_RD64;
                o_dec.is_wide  = 1'b1;
                o_dec.addr_inc = 1'b1;
            end
            OP_POLL32: begin
                o_dec.kind = KIND_POLL32;
            end
            OP_POLL64: begin
                o_dec.kind    = KIND_POLL64;
                o_dec.is_wide = 1'b1;
            end
            OP_RDIGN32: begin
                o_dec.kind = KIND_RDIGN32;
            end
            OP_INC_RDIGN32: begin
                o_dec.kind     = KIND_RDIGN32;
                o_dec.addr_inc = 1'b1;
            end
            OP_RDIGN64: begin
                o_dec.kind    = KIND_RDIGN64;
                o_dec.is_wide = 1'b1;
            end
            OP_INC_RDIGN64: begin
                o_dec.kind     = KIND_RDIGN64;
                o_dec.is_wide  = 1'b1;
                o_dec.addr_inc = 1'b1;
            end
            OP_WR32: begin
                o_dec.kind = KIND_WR32;
            end
            OP_INC_WR32: begin
                o_dec.kind     = KIND_WR32;
                o_dec.addr_inc = 1'b1;
            end
            OP_ZERO32: begin
                o_dec.kind     = KIND_WR32;
                o_dec.zero_val = 1'b1;
            end
            OP_INC_ZERO32: begin
                o_dec.kind     = KIND_WR32;
                o_dec.zero_val = 1'b1;
                o_dec.addr_inc = 1'b1;
            end
            OP_WR64: begin
                o_dec.kind    = KIND_WR64;
                o_dec.is_wide = 1'b1;
            end
            OP_INC_WR64: begin
                o_dec.kind     = KIND_WR64;
                o_dec.is_wide  = 1'b1;
                o_dec.addr_inc = 1'b1;
            end
            OP_ZERO64: begin
                o_dec.kind     = KIND_WR64;
                o_dec.is_wide  = 1'b1;
                o_dec.zero_val = 1'b1;
            end
            OP_INC_ZERO64: begin
                o_dec.kind     = KIND_WR64;
                o_dec.is_wide  = 1'b1;
                o_dec.zero_val = 1'b1;
                o_dec.addr_inc = 1'b1;
            end
            default: begin
                // unknown record, including a stray start header
                o_dec.kind     = KIND_ERROR;
                o_dec.is_wide  = 1'b1;
                o_dec.has_mask = 1'b0;
                o_dec.zero_val = 1'b1;
                o_dec.stop     = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/bari_exec.sv =====
`default_nettype none
`include "bus_action_record_interpreter_unit_macros.svh"
module bari_exec
    import bari_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_dec        i_dec,
    input  wire logic [63:0] i_payload,
    output logic             o_res_valid,
    output t_result          o_res
);

    logic [31:0] r_target;
    logic [63:0] r_addr;
    logic [31:0] r_nmask;
    logic [63:0] r_wmask;
    logic        r_stopped;

    logic        w_live;
    logic [63:0] w_step;
    logic [63:0] n_addr;

    assign w_live = i_fire && !r_stopped;

    // address after optional load or auto increment
    assign w_step = i_dec.is_wide ? ADDR_STEP_WIDE : ADDR_STEP_NARROW;
    always_comb begin
        n_addr = r_addr;
        if (i_dec.set_addr) begin
            n_addr = i_payload;
        end else if (i_dec.addr_inc) begin
            n_addr = r_addr + w_step;
        end
    end

    // interpreter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_addr    <= '0;
            r_nmask   <= '1;
            r_wmask   <= '1;
            r_stopped <= 1'b0;
        end else if (w_live) begin
            r_addr <= n_addr;
            if (i_dec.set_target) begin
                r_target <= i_payload[31:0];
            end
            if (i_dec.set_nmask) begin
                r_nmask <= i_payload[31:0];
            end
            if (i_dec.set_wmask) begin
                r_wmask <= i_payload;
            end
            if (i_dec.stop) begin
                r_stopped <= 1'b1;
            end
        end
    end

    // result beat
    assign o_res_valid = w_live && i_dec.emit;
    always_comb begin
        o_res.kind        = i_dec.kind;
        o_res.target_id   = r_target;
        o_res.bus_address = n_addr;
        if (i_dec.zero_val) begin
            o_res.data_value = '0;
        end else if (i_dec.is_wide) begin
            o_res.data_value = i_payload;
        end else begin
            o_res.data_value = {32'd0, i_payload[31:0]};
        end
        if (!i_dec.has_mask) begin
            o_res.compare_mask = '0;
        end else if (i_dec.is_wide) begin
            o_res.compare_mask = r_wmask;
        end else begin
            o_res.compare_mask = {32'd0, r_nmask};
        end
    end

    // checks
    `BARI_ASSERT_NEXT(a_stop_sticks, i_clk, i_rst_n, r_stopped, r_stopped)
    `BARI_ASSERT_NEXT(a_stop_on_final, i_clk, i_rst_n, w_live && i_dec.stop, r_stopped)
    `BARI_ASSERT_NEXT(a_addr_idle, i_clk, i_rst_n, !w_live, $stable(r_addr))
    `BARI_ASSERT_NOW(a_no_beat_stopped, i_clk, i_rst_n, r_stopped, !o_res_valid)

endmodule
`default_nettype wire

// ===== design/bari_out.sv =====
`default_nettype none
module bari_out
    import bari_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_result     i_res,
    input  wire logic        i_out_stall,
    output logic             o_free,
    output logic             o_out_valid,
    output t_result          o_res
);

    logic    r_valid;
    t_result r_res;

    // register may take a new beat when empty or draining
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

// ===== design/bus_action_record_interpreter_unit.sv =====
// Path: a record is captured in the input register, then decode and state update write the
//   result register. Throughput: one record per cycle unless the output stalls; the
//   64-bit address add sits between the two registers.
// Reset (synchronous, active low): target id and address to zero, both masks to all
//   ones, stopped flag cleared, both pipeline registers empty.
`default_nettype none
module bus_action_record_interpreter_unit
    import bari_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_opcode,
    input  wire logic [63:0] i_payload,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_action_kind,
    output logic [31:0]      o_target_id,
    output logic [63:0]      o_bus_address,
    output logic [63:0]      o_data_value,
    output logic [63:0]      o_compare_mask
);

    logic        r_s1_valid;
    logic [7:0]  r_s1_opcode;
    logic [63:0] r_s1_payload;

    logic        w_free;
    logic        w_fire;
    logic        w_accept;
    logic        w_res_valid;
    t_dec        w_dec;
    t_result     w_res;
    t_result     w_out;

    // input stage handshake
    assign w_fire     = r_s1_valid && w_free;
    assign o_in_stall = r_s1_valid && !w_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_opcode  <= i_opcode;
            r_s1_payload <= i_payload;
        end
    end

    // decode and execute
    bari_decode u_decode (
        .i_opcode (r_s1_opcode),
        .o_dec    (w_dec)
    );

    bari_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_dec       (w_dec),
        .i_payload   (r_s1_payload),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register
    bari_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_valid),
        .i_res       (w_res),
        .i_out_stall (i_out_stall),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .o_res       (w_out)
    );

    assign o_action_kind  = w_out.kind;
    assign o_target_id    = w_out.target_id;
    assign o_bus_address  = w_out.bus_address;
    assign o_data_value   = w_out.data_value;
    assign o_compare_mask = w_out.compare_mask;

endmodule
`default_nettype wire

// ===== test/tb_bus_action_record_interpreter_unit.sv =====
module tb_bus_action_record_interpreter_unit;
    import bari_pkg::*;

    localparam int unsigned RANDOM_RECORDS = 1170;
    localparam int unsigned PHASE_RECORDS  = 150;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES    = 12;
    localparam int unsigned REPORT_LIMIT   = 10;

    // opcodes that fall outside the record set
    localparam t_opcode OP_START_HEADER = 8'h02;
    localparam t_opcode OP_NOISE_LOW    = 8'h00;
    localparam t_opcode OP_NOISE_HIGH   = 8'hFF;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LOW_ONES = 64'h0000_0000_FFFF_FFFF;

    // record pools for the random part
    localparam t_opcode ACTION_OPS [18] = '{
        OP_RD32, OP_RD64, OP_WR32, OP_WR64, OP_INC_RD32, OP_INC_RD64,
        OP_INC_WR32, OP_INC_WR64, OP_ZERO32, OP_ZERO64, OP_INC_ZERO32, OP_INC_ZERO64,
        OP_RDIGN32, OP_RDIGN64, OP_INC_RDIGN32, OP_INC_RDIGN64, OP_POLL32, OP_POLL64
    };
    localparam t_opcode SETUP_OPS [4] = '{OP_SET_ID, OP_SET_ADDR, OP_SET_NMASK, OP_SET_WMASK};

    // one directed record, with a fixed expectation where it is obvious
    typedef struct packed {
        t_opcode     op;
        logic [63:0] pay;
        logic        fixed;
        t_result     res;
    } t_script_row;

    localparam t_script_row DIRECTED [26] = '{
        '{OP_RD32, ALL_ONES, 1'b1, '{KIND_RD32, 32'd0, 64'd0, LOW_ONES, LOW_ONES}},
        '{OP_RD64, ALL_ONES, 1'b1, '{KIND_RD64, 32'd0, 64'd0, ALL_ONES, ALL_ONES}},
        '{OP_WR32, 64'd0, 1'b1, '{KIND_WR32, 32'd0, 64'd0, 64'd0, LOW_ONES}},
        '{OP_SET_ID, 64'hFFFF_FFFF_0000_0000, 1'b0, '0},
        '{OP_POLL64, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{OP_SET_ID, ALL_ONES, 1'b0, '0},
        '{OP_SET_ADDR, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, '0},
        '{OP_INC_RD32, 64'hDEAD_BEEF_1234_5678, 1'b1,
          '{KIND_RD32, 32'hFFFF_FFFF, 64'd0, 64'h0000_0000_1234_5678, LOW_ONES}},
        '{OP_SET_ADDR, 64'hFFFF_FFFF_FFFF_FFF8, 1'b0, '0},
        '{OP_INC_WR64, ALL_ONES, 1'b1, '{KIND_WR64, 32'hFFFF_FFFF, 64'd0, ALL_ONES, ALL_ONES}},
        '{OP_SET_NMASK, 64'hFFFF_FFFF_0000_0000, 1'b0, '0},
        '{OP_SET_WMASK, 64'd0, 1'b0, '0},
        '{OP_WR64, 64'h8000_0000_0000_0001, 1'b0, '0},
        '{OP_INC_WR32, 64'h5555_5555_AAAA_AAAA, 1'b0, '0},
        '{OP_ZERO32, ALL_ONES, 1'b0, '0},
        '{OP_ZERO64, ALL_ONES, 1'b0, '0},
        '{OP_INC_ZERO32, 64'd1, 1'b0, '0},
        '{OP_INC_ZERO64, 64'd2, 1'b0, '0},
        '{OP_SET_NMASK, 64'h0000_0000_F0F0_F0F0, 1'b0, '0},
        '{OP_SET_WMASK, 64'h00FF_00FF_00FF_00FF, 1'b0, '0},
        '{OP_RDIGN32, 64'hCAFE_F00D_8765_4321, 1'b0, '0},
        '{OP_RDIGN64, 64'hAAAA_AAAA_5555_5555, 1'b0, '0},
        '{OP_INC_RDIGN32, 64'd7, 1'b0, '0},
        '{OP_INC_RDIGN64, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
        '{OP_POLL32, 64'h0000_0001_8000_0000, 1'b0, '0},
        '{OP_INC_RD64, 64'h1111_2222_3333_4444, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_opcode = '0;
    logic [63:0] in_payload = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [3:0]  action_kind;
    logic [31:0] target_id;
    logic [63:0] bus_address;
    logic [63:0] data_value;
    logic [63:0] compare_mask;

    // predicted interpreter state
    logic [31:0] cur_target;
    logic [63:0] cur_addr;
    logic [31:0] narrow_mask;
    logic [63:0] wide_mask;
    logic        halted;

    t_result     pending_actions [$];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    bus_action_record_interpreter_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (in_opcode),
        .i_payload      (in_payload),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_action_kind  (action_kind),
        .o_target_id    (target_id),
        .o_bus_address  (bus_address),
        .o_data_value   (data_value),
        .o_compare_mask (compare_mask)
    );

    always #6 clk = ~clk;

    // interpret one record; returns 1 when it produces an action beat
    function automatic bit predict_action(input t_opcode op, input logic [63:0] pay,
                                          output t_result r);
        t_kind kind;
        logic  wide;
        logic  step;
        logic  zero;
        r = '0;
        wide = 1'b0;
        step = 1'b0;
        zero = 1'b0;
        kind = KIND_ERROR;
        if (halted) return 1'b0;
        case (op)
            OP_SET_ID: begin
                cur_target = pay[31:0];
                return 1'b0;
            end
            OP_SET_ADDR: begin
                cur_addr = pay;
                return 1'b0;
            end
            OP_SET_NMASK: begin
                narrow_mask = pay[31:0];
                return 1'b0;
            end
            OP_SET_WMASK: begin
                wide_mask = pay;
                return 1'b0;
            end
            OP_END:         kind = KIND_END;
            OP_RD32:        kind = KIND_RD32;
            OP_INC_RD32:    begin kind = KIND_RD32; step = 1'b1; end
            OP_RD64:        begin kind = KIND_RD64; wide = 1'b1; end
            OP_INC_RD64:    begin kind = KIND_RD64; wide = 1'b1; step = 1'b1; end
            OP_WR32:        kind = KIND_WR32;
            OP_INC_WR32:    begin kind = KIND_WR32; step = 1'b1; end
            OP_ZERO32:      begin kind = KIND_WR32; zero = 1'b1; end
            OP_INC_ZERO32:  begin kind = KIND_WR32; zero = 1'b1; step = 1'b1; end
            OP_WR64:        begin kind = KIND_WR64; wide = 1'b1; end
            OP_INC_WR64:    begin kind = KIND_WR64; wide = 1'b1; step = 1'b1; end
            OP_ZERO64:      begin kind = KIND_WR64; wide = 1'b1; zero = 1'b1; end
            OP_INC_ZERO64:  begin kind = KIND_WR64; wide = 1'b1; zero = 1'b1; step = 1'b1; end
            OP_RDIGN32:     kind = KIND_RDIGN32;
            OP_INC_RDIGN32: begin kind = KIND_RDIGN32; step = 1'b1; end
            OP_RDIGN64:     begin kind = KIND_RDIGN64; wide = 1'b1; end
            OP_INC_RDIGN64: begin kind = KIND_RDIGN64; wide = 1'b1; step = 1'b1; end
            OP_POLL32:      kind = KIND_POLL32;
            OP_POLL64:      begin kind = KIND_POLL64; wide = 1'b1; end
            default:        kind = KIND_ERROR;
        endcase
        // auto increment wraps at 2^64
        if (step) cur_addr = cur_addr + (wide ? 64'd8 : 64'd4);
        r.kind = kind;
        r.target_id = cur_target;
        r.bus_address = cur_addr;
        if (kind == KIND_END || kind == KIND_ERROR) begin
            halted = 1'b1;
        end else begin
            r.data_value = zero ? 64'd0 : (wide ? pay : {32'd0, pay[31:0]});
            r.compare_mask = wide ? wide_mask : {32'd0, narrow_mask};
        end
        return 1'b1;
    endfunction

    // present one record beat and hold it until taken
    task automatic send_record(input t_opcode op, input logic [63:0] pay,
                               input logic use_fixed, input t_result fixed_res);
        t_result r;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_opcode <= op;
        in_payload <= pay;
        do @(posedge clk); while (in_stall);
        if (predict_action(op, pay, r)) pending_actions.push_back(use_fixed ? fixed_res : r);
    endtask

    // receiver back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // compare each action beat with the oldest prediction
    always @(posedge clk) begin : action_check
        t_result got;
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{action_kind, target_id, bus_address, data_value, compare_mask};
            if (pending_actions.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected action beat: kind %0d id %h addr %h data %h mask %h",
                             got.kind, got.target_id, got.bus_address, got.data_value,
                             got.compare_mask);
            end else begin
                want = pending_actions.pop_front();
                if (got.kind !== want.kind || got.target_id !== want.target_id ||
                    got.bus_address !== want.bus_address ||
                    got.data_value !== want.data_value ||
                    got.compare_mask !== want.compare_mask) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("action mismatch, expected: kind %0d id %h addr %h data %h mask %h",
                                 want.kind, want.target_id, want.bus_address, want.data_value,
                                 want.compare_mask);
                        $display("                 actual:   kind %0d id %h addr %h data %h mask %h",
                                 got.kind, got.target_id, got.bus_address, got.data_value,
                                 got.compare_mask);
                    end
                end
            end
        end
    end

    // count cycles in which neither side moves a beat
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_opcode     op;
        logic [63:0] pay;
        cur_target = '0;
        cur_addr = '0;
        narrow_mask = '1;
        wide_mask = '1;
        halted = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed records
        foreach (DIRECTED[k])
            send_record(DIRECTED[k].op, DIRECTED[k].pay, DIRECTED[k].fixed, DIRECTED[k].res);

        // random well-formed stream, idling pattern changes every phase
        for (int unsigned n = 0; n < RANDOM_RECORDS; n++) begin
            case ((n / PHASE_RECORDS) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if ($urandom_range(99) < 22) begin
                op = SETUP_OPS[$urandom_range(3)];
            end else begin
                op = ACTION_OPS[$urandom_range(17)];
            end
            case ($urandom_range(7))
                0: pay = '0;
                1: pay = '1;
                2: pay = {32'd0, $urandom};
                3: pay = {$urandom, 32'hFFFF_FFFF};
                default: pay = {$urandom, $urandom};
            endcase
            // land the address near the top so increments wrap
            if (op == OP_SET_ADDR && $urandom_range(3) == 0)
                pay = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(15));
            send_record(op, pay, 1'b0, '0);
        end

        // close the stream with an end record, a stray start header or an unknown opcode
        case ($urandom_range(2))
            0: op = OP_END;
            1: op = OP_START_HEADER;
            default: op = {5'($urandom_range(31)), 3'($urandom_range(7, 3))};
        endcase
        send_record(op, {$urandom, $urandom}, 1'b0, '0);

        // stopped: everything from here on is swallowed
        send_record(OP_NOISE_LOW, '0, 1'b0, '0);
        send_record(OP_NOISE_HIGH, '1, 1'b0, '0);
        send_record(OP_END, '0, 1'b0, '0);
        repeat (8) send_record(8'($urandom_range(255)), {$urandom, $urandom}, 1'b0, '0);

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_actions.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
